// ===== sv/fit_policy_block_allocator_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the fit policy block allocator
// Shared property wrappers used by the RTL file that carries assertions.
// ---------------------------------------------------------------------------
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FPBA_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("fpba assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FPBA_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("fpba assertion failed");

`endif

// ===== sv/fpba_pkg.sv =====
// ---------------------------------------------------------------------------
// Fit policy block allocator package
// Codes, defaults and shared types of the allocator and its cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpba_pkg;

   localparam int MAX_BLOCKS_DEFAULT = 32;
   localparam int SIZE_BITS_DEFAULT  = 16;

   // Operation codes of a request beat.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   // Fit policy codes; the unused code behaves as first fit.
   localparam logic [1:0] POLICY_FIRST = 2'd0;
   localparam logic [1:0] POLICY_BEST  = 2'd1;
   localparam logic [1:0] POLICY_WORST = 2'd2;

   // Response status codes.
   localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT    = 2'd1;
   localparam logic [1:0] STATUS_LOADED    = 2'd2;

   // Register indexes of the configuration port.
   localparam logic CSR_FIT_POLICY  = 1'b0;
   localparam logic CSR_BLOCK_COUNT = 1'b1;

   // Control part of the search candidate handed from cell to cell.
   typedef struct packed {
      logic valid;
      logic found;
   } cand_ctrl_type;

   // Scan sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } state_type;

endpackage

// ===== sv/fpba_cell.sv =====
// ---------------------------------------------------------------------------
// Allocator cell
// Holds one block's remaining size and updates the passing search candidate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpba_cell
   import fpba_pkg::*;
#(
   parameter int CELL_INDEX = 0,
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT,
   parameter int SIZE_BITS  = SIZE_BITS_DEFAULT,
   localparam int IDX_BITS  = $clog2(MAX_BLOCKS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           fit_policy,
   input  logic [5:0]           block_count,
   input  logic [SIZE_BITS-1:0] request,
   input  logic                 wr_en,
   input  logic [SIZE_BITS-1:0] wr_data,
   input  cand_ctrl_type        cand_in,
   input  logic [IDX_BITS-1:0]  sel_in,
   input  logic [SIZE_BITS-1:0] sel_val_in,
   output cand_ctrl_type        cand_out,
   output logic [IDX_BITS-1:0]  sel_out,
   output logic [SIZE_BITS-1:0] sel_val_out
);

   logic [SIZE_BITS-1:0] value_ff;
   cand_ctrl_type        cand_ff;
   logic [IDX_BITS-1:0]  sel_ff;
   logic [SIZE_BITS-1:0] sel_val_ff;

   logic active;
   logic fits;
   logic take;

   assign active = (32'(block_count) > CELL_INDEX);
   assign fits   = active && (value_ff >= request);

   // A fitting cell wins when no earlier cell fit, or when it is strictly
   // better under best or worst fit; ties stay with the lower index.
   always_comb begin
      take = 1'b0;
      if (fits) begin
         if (!cand_in.found) begin
            take = 1'b1;
         end else if (fit_policy == POLICY_BEST) begin
            take = (value_ff < sel_val_in);
         end else if (fit_policy == POLICY_WORST) begin
            take = (value_ff > sel_val_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff      <= '0;
         cand_ff.valid <= 1'b0;
         cand_ff.found <= 1'b0;
      end else begin
         if (wr_en) begin
            value_ff <= wr_data;
         end
         cand_ff.valid <= cand_in.valid;
         cand_ff.found <= cand_in.found || fits;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff     <= take ? IDX_BITS'(CELL_INDEX) : sel_in;
      sel_val_ff <= take ? value_ff : sel_val_in;
   end

   assign cand_out    = cand_ff;
   assign sel_out     = sel_ff;
   assign sel_val_out = sel_val_ff;

endmodule

// ===== sv/fit_policy_block_allocator.sv =====
// ---------------------------------------------------------------------------
// Fit policy block allocator
// First, best or worst fit allocation over a row of block size cells.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// req       in         req_valid / req_ready      operation, block_index, size_value
// rsp       out        rsp_valid / rsp_ready      status, chosen_block, left_over
// csr       in         csr_valid / csr_ready      index, data
//
// A load beat passes through the response state to the output register.
// An allocate beat reaches its response beat once the search candidate
// has walked the row of cells, one cell per cycle.
// Reset is synchronous and clears every block size and both registers.
// One request is in flight at a time; a stalled response holds the next
// finished result in the sequencer until the output register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fit_policy_block_allocator_macros.svh"

module fit_policy_block_allocator
   import fpba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT,
   parameter int SIZE_BITS  = SIZE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [4:0]  req_block_index,
   input  logic [15:0] req_size_value,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_chosen_block,
   output logic [15:0] rsp_left_over,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [5:0]  csr_data
);

   localparam int IDX_BITS = $clog2(MAX_BLOCKS);

   // Configuration registers.
   logic [1:0] policy_ff;
   logic [5:0] count_ff;

   // Sequencer state and the request under search.
   state_type            state_ff;
   state_type            state_in;
   logic [SIZE_BITS-1:0] request_ff;
   logic                 start_ff;

   // Result waiting for the output register.
   logic [1:0]  res_status_ff;
   logic [4:0]  res_chosen_ff;
   logic [15:0] res_left_ff;

   // Output register.
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [4:0]  rsp_chosen_ff;
   logic [15:0] rsp_left_ff;

   // Candidate chain: entry 0 feeds the first cell, the last entry leaves
   // the final cell.
   cand_ctrl_type        cand_chain    [MAX_BLOCKS+1];
   logic [IDX_BITS-1:0]  sel_chain     [MAX_BLOCKS+1];
   logic [SIZE_BITS-1:0] sel_val_chain [MAX_BLOCKS+1];

   logic                 req_fire;
   logic                 scan_done;
   logic                 commit;
   logic                 out_free;
   logic [SIZE_BITS-1:0] rest;
   logic [SIZE_BITS-1:0] wr_data;
   logic [MAX_BLOCKS-1:0] wr_en;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // The scan ends when the candidate leaves the last cell. The chosen cell
   // still holds the size carried by the candidate, so one subtract gives
   // the write-back value.
   assign scan_done = (state_ff == ST_SCAN) && cand_chain[MAX_BLOCKS].valid;
   assign commit    = scan_done && cand_chain[MAX_BLOCKS].found;
   assign rest      = sel_val_chain[MAX_BLOCKS] - request_ff;

   // Loads are only accepted in idle and write-backs only end a scan, so the
   // two never share a cycle.
   assign wr_data = (state_ff == ST_SCAN) ? rest : SIZE_BITS'(req_size_value);

   assign cand_chain[0].valid = start_ff;
   assign cand_chain[0].found = 1'b0;
   assign sel_chain[0]        = '0;
   assign sel_val_chain[0]    = '0;

   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cells
      assign wr_en[i] =
         (req_fire && (req_operation == OP_LOAD) && (32'(req_block_index) == i)) ||
         (commit && (32'(sel_chain[MAX_BLOCKS]) == i));

      fpba_cell #(
         .CELL_INDEX (i),
         .MAX_BLOCKS (MAX_BLOCKS),
         .SIZE_BITS  (SIZE_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .fit_policy  (policy_ff),
         .block_count (count_ff),
         .request     (request_ff),
         .wr_en       (wr_en[i]),
         .wr_data     (wr_data),
         .cand_in     (cand_chain[i]),
         .sel_in      (sel_chain[i]),
         .sel_val_in  (sel_val_chain[i]),
         .cand_out    (cand_chain[i+1]),
         .sel_out     (sel_chain[i+1]),
         .sel_val_out (sel_val_chain[i+1])
      );
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_FIRST;
         count_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FIT_POLICY:  policy_ff <= csr_data[1:0];
            CSR_BLOCK_COUNT: count_ff  <= csr_data;
            default:         count_ff  <= count_ff;
         endcase
      end
   end

   // Sequencer: idle takes a beat, scan waits for the candidate, and the
   // response state hands the result to the output register.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_operation == OP_ALLOC) ? ST_SCAN : ST_RESP;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= req_fire && (req_operation == OP_ALLOC);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         request_ff    <= SIZE_BITS'(req_size_value);
         res_status_ff <= STATUS_LOADED;
         res_chosen_ff <= '0;
         res_left_ff   <= '0;
      end else if (scan_done) begin
         if (commit) begin
            res_status_ff <= STATUS_ALLOCATED;
            res_chosen_ff <= 5'(sel_chain[MAX_BLOCKS]);
            res_left_ff   <= 16'(rest);
         end else begin
            res_status_ff <= STATUS_NO_FIT;
            res_chosen_ff <= '0;
            res_left_ff   <= '0;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_RESP) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_RESP) && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_chosen_ff <= res_chosen_ff;
         rsp_left_ff   <= res_left_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen_block = rsp_chosen_ff;
   assign rsp_left_over    = rsp_left_ff;

   // The candidate only leaves the row while a scan is running.
   `FPBA_ASSERT_SAME(a_cand_in_scan, clock, reset,
      cand_chain[MAX_BLOCKS].valid, state_ff == ST_SCAN)
   // At most one cell is written in any cycle.
   `FPBA_ASSERT_SAME(a_single_write, clock, reset, 1'b1, $onehot0(wr_en))
   // An allocate beat always starts a candidate on the next cycle.
   `FPBA_ASSERT_NEXT(a_start_follows, clock, reset,
      req_fire && (req_operation == OP_ALLOC), start_ff && (state_ff == ST_SCAN))
   // A no-fit response carries zero index and zero left over size.
   `FPBA_ASSERT_SAME(a_no_fit_zero, clock, reset,
      rsp_valid_ff && (rsp_status_ff == STATUS_NO_FIT),
      (rsp_chosen_ff == '0) && (rsp_left_ff == '0))

endmodule

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// Testbench for the fit policy block allocator
// Loads block sizes and sends allocate requests under every fit policy and
// a range of block counts. A local copy of the size table predicts each
// response beat, and the beat is checked field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
   import fpba_pkg::*;
();

   localparam int MAX_BLOCKS = MAX_BLOCKS_DEFAULT;

   // One request beat as the driver presents it.
   typedef struct packed {
      logic        operation;
      logic [4:0]  block_index;
      logic [15:0] size_value;
   } alloc_req_type;

   // One response beat as the monitor sees it.
   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  chosen_block;
      logic [15:0] left_over;
   } alloc_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = 1'b0;
   logic [4:0]  req_block_index = '0;
   logic [15:0] req_size_value = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_chosen_block;
   logic [15:0] rsp_left_over;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [5:0]  csr_data = '0;

   // Beats waiting to be driven, and responses predicted but not yet seen.
   alloc_req_type request_backlog[$];
   alloc_rsp_type awaited_answers[$];

   // Local copy of the allocator state: the size table and both registers.
   logic [15:0] free_size [MAX_BLOCKS];
   logic [1:0]  policy_now = POLICY_FIRST;
   logic [5:0]  count_now = '0;

   // Idle limits of the two sides, changed from phase to phase.
   int unsigned req_gap_max = 10;
   int unsigned rsp_stall_max = 10;
   int unsigned req_gap = 0;
   int unsigned rsp_stall = 0;

   // Handshakes seen at the last rising edge, for the drivers at the falling edge.
   logic        req_took = 1'b0;
   logic        rsp_took = 1'b0;

   int unsigned mismatch_count = 0;
   alloc_req_type next_beat;
   alloc_rsp_type want;
   alloc_rsp_type got;

   fit_policy_block_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_block_index  (req_block_index),
      .req_size_value   (req_size_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_left_over    (rsp_left_over),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #10 clock = ~clock;

   // Works out the response to one accepted beat and updates the local table.
   // A load always answers with the loaded status and zero fields. An allocate
   // scans the blocks in use; the first block that fits is taken at once under
   // first fit (and under the unused policy code), while best and worst fit
   // only move to a later block when it is strictly smaller or larger, so
   // ties stay with the lowest index.
   function automatic alloc_rsp_type fit_answer(input alloc_req_type beat);
      alloc_rsp_type answer;
      int span;
      int j;
      int pick;
      bit found;
      answer = '{STATUS_LOADED, 5'd0, 16'd0};
      if (beat.operation == OP_LOAD) begin
         free_size[beat.block_index] = beat.size_value;
         return answer;
      end
      // A count above the table size means the whole table.
      span = (count_now > MAX_BLOCKS) ? MAX_BLOCKS : int'(count_now);
      found = 1'b0;
      pick = 0;
      for (j = 0; j < span; j++) begin
         if (free_size[j] >= beat.size_value) begin
            if (!found ||
                (policy_now == POLICY_BEST && free_size[j] < free_size[pick]) ||
                (policy_now == POLICY_WORST && free_size[j] > free_size[pick])) begin
               pick = j;
            end
            found = 1'b1;
         end
      end
      if (!found) begin
         answer.status = STATUS_NO_FIT;
      end else begin
         free_size[pick] = free_size[pick] - beat.size_value;
         answer = '{STATUS_ALLOCATED, pick[4:0], free_size[pick]};
      end
      return answer;
   endfunction

   task automatic report_field(input string name, input int unsigned expected_value,
                               input int unsigned actual_value);
      if (expected_value != actual_value) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                  expected_value, actual_value);
         mismatch_count++;
      end
   endtask

   // Monitor. Both channels are sampled at the rising edge, before the
   // allocator's registers take their new values. An accepted request beat is
   // run through the predictor right away; an accepted response beat is
   // compared with the oldest prediction.
   always @(posedge clock) begin
      req_took <= !reset && req_valid && req_ready;
      rsp_took <= !reset && rsp_valid && rsp_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            next_beat = '{req_operation, req_block_index, req_size_value};
            awaited_answers.push_back(fit_answer(next_beat));
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_status, rsp_chosen_block, rsp_left_over};
            if (awaited_answers.size() == 0) begin
               $display({"%0t: response beat with nothing expected, ",
                         "actual status %0d block %0d left %0d"},
                        $time, got.status, got.chosen_block, got.left_over);
               mismatch_count++;
            end else begin
               want = awaited_answers.pop_front();
               report_field("status", want.status, got.status);
               report_field("chosen_block", want.chosen_block, got.chosen_block);
               report_field("left_over", want.left_over, got.left_over);
            end
         end
      end
   end

   // Request driver. It changes the channel only at the falling edge, and only
   // once the beat on the channel has been taken. After each beat it idles for
   // the gap drawn when that beat was put up. When the next beat
   // follows at once, valid simply stays high with the new payload.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (req_gap != 0) begin
            req_gap = req_gap - 1;
            req_valid <= 1'b0;
         end else if (request_backlog.size() != 0) begin
            next_beat = request_backlog.pop_front();
            req_operation <= next_beat.operation;
            req_block_index <= next_beat.block_index;
            req_size_value <= next_beat.size_value;
            req_valid <= 1'b1;
            req_gap = $urandom_range(0, req_gap_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side. Before each response beat the receiver stalls for a drawn
   // length of time; ready drops whether or not a beat is waiting, so the
   // stalls land on every phase of the allocator's scan.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_took) begin
            rsp_stall = $urandom_range(0, rsp_stall_max);
         end
         if (rsp_stall != 0) begin
            rsp_stall = rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic push_beat(input logic operation, input logic [4:0] block_index,
                            input logic [15:0] size_value);
      request_backlog.push_back('{operation, block_index, size_value});
   endtask

   // Writes one register and mirrors it into the local copy once accepted.
   // The copy keeps only the bits the register holds.
   task automatic write_register(input logic index, input logic [5:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_FIT_POLICY) begin
         policy_now = data[1:0];
      end else begin
         count_now = data;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Holds the sender until every queued beat has gone out and every
   // response has come back. Checked at the rising edge, where valid and the
   // queues are stable.
   task automatic wait_for_drain();
      do @(posedge clock);
      while (request_backlog.size() != 0 || req_valid || awaited_answers.size() != 0);
   endtask

   initial begin : stimulus
      int phase;
      int i;
      int span;
      int unsigned scale;
      int unsigned roll;
      logic [5:0] reg_data;
      logic [5:0] count_pick;
      logic [4:0] index_pick;
      logic [15:0] size_pick;

      for (i = 0; i < MAX_BLOCKS; i++) begin
         free_size[i] = '0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the block count at its reset value of zero nothing is searched,
      // so even a zero request finds no fit.
      push_beat(OP_ALLOC, 5'd0, 16'd0);
      wait_for_drain();

      // First fit over four blocks. Loads outside the count still land in
      // the table; the largest request that fits empties block 0.
      write_register(CSR_BLOCK_COUNT, 6'd4);
      push_beat(OP_LOAD, 5'd0, 16'hFFFF);
      push_beat(OP_LOAD, 5'd1, 16'd0);
      push_beat(OP_LOAD, 5'd2, 16'd100);
      push_beat(OP_LOAD, 5'd3, 16'd100);
      push_beat(OP_LOAD, 5'd31, 16'hAAAA);
      push_beat(OP_LOAD, 5'd21, 16'h5555);
      push_beat(OP_ALLOC, 5'd31, 16'd100);
      push_beat(OP_ALLOC, 5'd0, 16'hFF9C);
      push_beat(OP_ALLOC, 5'd10, 16'hFF9B);
      wait_for_drain();

      // Best fit. A zero request fits an empty block, and the tie between
      // blocks 0 and 1 goes to block 0; equal blocks 2 and 3 tie the same way.
      write_register(CSR_FIT_POLICY, {4'b0000, POLICY_BEST});
      push_beat(OP_ALLOC, 5'd0, 16'd0);
      push_beat(OP_ALLOC, 5'd0, 16'd50);
      push_beat(OP_ALLOC, 5'd0, 16'd50);
      wait_for_drain();

      // Worst fit, written with the upper data bits set. A request one above
      // the largest block finds no fit.
      write_register(CSR_FIT_POLICY, {4'b1111, POLICY_WORST});
      push_beat(OP_LOAD, 5'd1, 16'hFFFF);
      push_beat(OP_ALLOC, 5'd0, 16'd1);
      push_beat(OP_ALLOC, 5'd0, 16'hFFFF);
      wait_for_drain();

      // The unused policy code acts as first fit, and a count of 63 covers
      // the whole table, so block 31 is reachable.
      write_register(CSR_FIT_POLICY, 6'b010111);
      write_register(CSR_BLOCK_COUNT, 6'd63);
      push_beat(OP_ALLOC, 5'd0, 16'hAAAA);
      push_beat(OP_ALLOC, 5'd0, 16'hFFFF);
      push_beat(OP_LOAD, 5'd31, 16'hFFFF);
      push_beat(OP_ALLOC, 5'd0, 16'hFFFF);

      // Random phases. Each phase waits for the allocator to drain before
      // its registers are rewritten, which also makes the sender pause
      // until every response is back. A phase opens by loading every block
      // in use, then mixes loads and requests whose sizes are scaled so that
      // both fits and misses are common. A small share of requests use the
      // full size range as noise.
      for (phase = 0; phase < 16; phase++) begin
         wait_for_drain();
         req_gap_max = (phase % 4 == 1) ? 0 : 10;
         rsp_stall_max = (phase % 4 == 2) ? 0 : 10;
         reg_data = 6'($urandom);
         reg_data[1:0] = 2'(phase % 4);
         write_register(CSR_FIT_POLICY, reg_data);
         case (phase % 8)
            0: count_pick = 6'd1;
            1: count_pick = 6'd2;
            2: count_pick = 6'd32;
            3: count_pick = 6'($urandom_range(33, 63));
            4: count_pick = 6'($urandom_range(3, 8));
            5: count_pick = 6'($urandom_range(1, 32));
            6: count_pick = 6'd0;
            default: count_pick = 6'd63;
         endcase
         write_register(CSR_BLOCK_COUNT, count_pick);
         span = (count_pick > MAX_BLOCKS) ? MAX_BLOCKS : int'(count_pick);
         case ($urandom_range(0, 2))
            0: scale = 15;
            1: scale = 255;
            default: scale = 65535;
         endcase
         for (i = 0; i < 100; i++) begin
            roll = $urandom_range(0, 99);
            index_pick = 5'($urandom_range(0, 31));
            if (i < span) begin
               push_beat(OP_LOAD, i[4:0], 16'($urandom_range(0, scale)));
            end else if (roll < 35) begin
               if (span > 0 && roll < 30) begin
                  index_pick = 5'($urandom_range(0, span - 1));
               end
               size_pick = (roll < 2) ? 16'hFFFF : 16'($urandom_range(0, scale));
               push_beat(OP_LOAD, index_pick, size_pick);
            end else begin
               if (roll >= 96) begin
                  size_pick = 16'($urandom_range(0, 65535));
               end else if (roll >= 93) begin
                  size_pick = 16'd0;
               end else begin
                  size_pick = 16'($urandom_range(0, scale / 4));
               end
               push_beat(OP_ALLOC, index_pick, size_pick);
            end
         end
      end

      // Let the last responses come back, then give the scan time to show
      // any beat that should not be there.
      wait_for_drain();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: a correct run takes about a tenth of this.
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
